### hw/rtl/x86_16bit_branch_resolver_macros.svh
// Assertion helpers for the branch resolver
`ifndef X86_16BIT_BRANCH_RESOLVER_MACROS_SVH
`define X86_16BIT_BRANCH_RESOLVER_MACROS_SVH

// same-cycle implication, disabled in reset
`define BRU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("branch resolver check failed");

// next-cycle implication, disabled in reset
`define BRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("branch resolver check failed");

`endif

### hw/rtl/bru_pkg.sv
`default_nettype none

package bru_pkg;

  localparam int unsigned OpW     = 5;
  localparam int unsigned WordW   = 16;
  localparam int unsigned InDataW = 72;
  localparam int unsigned OutDataW = 56;

  localparam logic [OpW-1:0] OP_JMP16 = 5'd0;
  localparam logic [OpW-1:0] OP_JMP8  = 5'd1;
  localparam logic [OpW-1:0] OP_FAR   = 5'd2;
  localparam logic [OpW-1:0] OP_JO    = 5'd3;
  localparam logic [OpW-1:0] OP_JG    = 5'd18;
  localparam logic [OpW-1:0] OP_LOOP  = 5'd19;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_JMP16,
    CLS_JMP8,
    CLS_FAR,
    CLS_JCC,
    CLS_LOOP
  } cls_e;

  typedef struct packed {
    cls_e             cls;
    logic             cond;
    logic [WordW-1:0] ip;
    logic [WordW-1:0] fall;
    logic [WordW-1:0] ip3;
    logic [WordW-1:0] word;
    logic [WordW-1:0] seg;
    logic [WordW-1:0] cnt_m1;
  } dec_t;

  // packed so that next_ip sits in the low bits
  typedef struct packed {
    logic             count_write;
    logic [WordW-1:0] count_out;
    logic             taken;
    logic             cs_write;
    logic [WordW-1:0] next_cs;
    logic [WordW-1:0] next_ip;
  } res_t;

  // condition test of the sixteen Jcc forms; odd offsets from OP_JO are the negations
  function automatic logic cond_holds(logic [OpW-1:0] op, logic cf, logic zf,
                                      logic sf, logic of, logic pf);
    logic [OpW-1:0] k;
    logic           c;
    k = op - OP_JO;
    unique case (k[3:1])
      3'd0: c = of;
      3'd1: c = cf;
      3'd2: c = zf;
      3'd3: c = cf | zf;
      3'd4: c = sf;
      3'd5: c = pf;
      3'd6: c = sf ^ of;
      3'd7: c = zf | (sf ^ of);
      default: c = 1'b0;
    endcase
    return k[0] ? ~c : c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/x86_16bit_branch_resolver.sv
// 8086 jump and branch resolver: one jump-class instruction per transfer in, one result
// per transfer out, in order. A new instruction is taken every cycle unless the output
// stalls. There are three register stages: decode, target-add and output. Each stage
// advances while it is empty or the one after it accepts, so back-pressure on the
// output stalls the pipe without loss. op selects jmp rel16, jmp rel8, far jmp, the
// sixteen Jcc tests or loop; undefined op codes return next_ip = opcode_ip and all
// else zero. All address and count arithmetic wraps at 16 bits.
`default_nettype none
`include "x86_16bit_branch_resolver_macros.svh"

module x86_16bit_branch_resolver (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] opcode_ip, [31:16] operand_word, [47:32] segment_word, [48] carry_flag,
  // [49] zero_flag, [50] sign_flag, [51] overflow_flag, [52] parity_flag,
  // [68:53] count_in, [71:69] zero
  input  wire logic [bru_pkg::InDataW-1:0] s_axis_tdata,
  // [4:0] op
  input  wire logic [bru_pkg::OpW-1:0]     s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [15:0] next_ip, [31:16] next_cs, [32] cs_write, [33] taken,
  // [49:34] count_out, [50] count_write, [55:51] zero
  output logic [bru_pkg::OutDataW-1:0]     m_axis_tdata
);
  import bru_pkg::*;

  logic dec_valid, dec_ready;
  dec_t dec;
  logic res_valid, res_ready;
  res_t res;
  res_t out_res;

  bru_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .data_i      (s_axis_tdata),
    .out_valid_o (dec_valid),
    .out_ready_i (dec_ready),
    .out_o       (dec)
  );

  bru_resolve u_resolve (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dec_valid),
    .in_ready_o  (dec_ready),
    .in_i        (dec),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .out_o       (res)
  );

  bru_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (res_ready),
    .in_i        (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  assign out_res = m_axis_tdata[$bits(res_t)-1:0];

  `BRU_ASSERT_NOW(a_far_excl, clk_i, rst_ni, m_axis_tvalid && out_res.cs_write,
                  out_res.taken && !out_res.count_write)
  `BRU_ASSERT_NOW(a_loop_taken, clk_i, rst_ni, m_axis_tvalid && out_res.count_write,
                  out_res.taken == (out_res.count_out != '0))
  `BRU_ASSERT_NOW(a_cs_zero, clk_i, rst_ni, m_axis_tvalid && !out_res.cs_write,
                  out_res.next_cs == '0)
  `BRU_ASSERT_NEXT(a_fill, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, dec_valid)

endmodule

`default_nettype wire

### hw/rtl/bru_decode.sv
`default_nettype none

module bru_decode (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [bru_pkg::OpW-1:0]      op_i,
  input  wire logic [bru_pkg::InDataW-1:0]  data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output bru_pkg::dec_t                     out_o
);
  import bru_pkg::*;

  logic valid_q;
  dec_t dec_d, dec_q;
  logic [WordW-1:0] ip;
  logic [WordW-1:0] cnt;

  assign ip  = data_i[15:0];
  assign cnt = data_i[68:53];

  always_comb begin
    if (op_i == OP_JMP16) begin
      dec_d.cls = CLS_JMP16;
    end else if (op_i == OP_JMP8) begin
      dec_d.cls = CLS_JMP8;
    end else if (op_i == OP_FAR) begin
      dec_d.cls = CLS_FAR;
    end else if (op_i >= OP_JO && op_i <= OP_JG) begin
      dec_d.cls = CLS_JCC;
    end else if (op_i == OP_LOOP) begin
      dec_d.cls = CLS_LOOP;
    end else begin
      dec_d.cls = CLS_NONE;
    end
    dec_d.cond   = cond_holds(op_i, data_i[48], data_i[49], data_i[50], data_i[51],
                              data_i[52]);
    dec_d.ip     = ip;
    dec_d.fall   = ip + WordW'(2);
    dec_d.ip3    = ip + WordW'(3);
    dec_d.word   = data_i[31:16];
    dec_d.seg    = data_i[47:32];
    dec_d.cnt_m1 = cnt - WordW'(1);
  end

  assign in_ready_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      dec_q <= dec_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = dec_q;

endmodule

`default_nettype wire

### hw/rtl/bru_resolve.sv
`default_nettype none

module bru_resolve (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire bru_pkg::dec_t in_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output bru_pkg::res_t out_o
);
  import bru_pkg::*;

  logic valid_q;
  res_t res_d, res_q;
  logic [WordW-1:0] t8;
  logic [WordW-1:0] t16;
  logic             loop_tk;

  assign t8      = in_i.fall + {{8{in_i.word[7]}}, in_i.word[7:0]};
  assign t16     = in_i.ip3 + in_i.word;
  assign loop_tk = (in_i.cnt_m1 != '0);

  always_comb begin
    res_d = '0;
    res_d.next_ip = in_i.ip;
    unique case (in_i.cls)
      CLS_JMP16: begin
        res_d.next_ip = t16;
        res_d.taken   = 1'b1;
      end
      CLS_JMP8: begin
        res_d.next_ip = t8;
        res_d.taken   = 1'b1;
      end
      CLS_FAR: begin
        res_d.next_ip  = in_i.word;
        res_d.next_cs  = in_i.seg;
        res_d.cs_write = 1'b1;
        res_d.taken    = 1'b1;
      end
      CLS_JCC: begin
        res_d.taken   = in_i.cond;
        res_d.next_ip = in_i.cond ? t8 : in_i.fall;
      end
      CLS_LOOP: begin
        res_d.count_out   = in_i.cnt_m1;
        res_d.count_write = 1'b1;
        res_d.taken       = loop_tk;
        res_d.next_ip     = loop_tk ? t8 : in_i.fall;
      end
      default: begin
        res_d.next_ip = in_i.ip;
      end
    endcase
  end

  assign in_ready_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

`default_nettype wire

### hw/rtl/bru_out.sv
`default_nettype none

module bru_out (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire bru_pkg::res_t                in_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [bru_pkg::OutDataW-1:0]      out_data_o
);
  import bru_pkg::*;

  logic valid_q;
  logic [OutDataW-1:0] data_d, data_q;

  assign data_d     = OutDataW'(in_i);
  assign in_ready_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire
